FILE: hdl/rle_rgb565_sprite_blitter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sprite blitter
// Shared concurrent-check helpers, clocked on the rising edge, reset-gated.
// ---------------------------------------------------------------------------
`ifndef RLE_RGB565_SPRITE_BLITTER_DEFINES_SVH
`define RLE_RGB565_SPRITE_BLITTER_DEFINES_SVH

// Same-cycle implication.
`define RLEBL_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rlebl check failed");

// Next-cycle implication.
`define RLEBL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rlebl check failed");

`endif

FILE: hdl/rlebl_pkg.sv
// ---------------------------------------------------------------------------
// rlebl_pkg
// Types and constants shared by the sprite blitter modules.
// ---------------------------------------------------------------------------
package rlebl_pkg;

    localparam int LOGO_WIDTH  = 256;
    localparam int LOGO_HEIGHT = 256;
    localparam int MAX_RUN     = 64;
    localparam int ORIGIN_LIFT = 20;

    localparam int DIM_W    = 13;
    localparam int ORIGIN_W = DIM_W - 1;
    localparam int OFFSET_W = 26;
    localparam int WORD_W   = 24;
    localparam int LEN_W    = 7;
    localparam int COLOR_W  = 16;
    localparam int COL_W    = $clog2(LOGO_WIDTH + 1);
    localparam int ROW_W    = $clog2(LOGO_HEIGHT + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_LINE_STRIDE   = 2'd2,
        REG_RED_LOW       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] screen_width;
        logic [DIM_W-1:0] screen_height;
        logic [DIM_W-1:0] line_stride;
        logic             red_in_low_byte;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ORIGIN,
        S_POS,
        S_BASE,
        S_EMIT
    } eng_state_t;

endpackage

FILE: hdl/rlebl_cfg.sv
// ---------------------------------------------------------------------------
// rlebl_cfg
// APB register file holding screen geometry and channel order.
// ---------------------------------------------------------------------------
module rlebl_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlebl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rlebl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rlebl_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output rlebl_pkg::cfg_t                   cfg
);
    import rlebl_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width    <= DIM_W'(1024);
            cfg_reg.screen_height   <= DIM_W'(768);
            cfg_reg.line_stride     <= DIM_W'(1024);
            cfg_reg.red_in_low_byte <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width    <= pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height   <= pwdata[DIM_W-1:0];
                REG_LINE_STRIDE:   cfg_reg.line_stride     <= pwdata[DIM_W-1:0];
                REG_RED_LOW:       cfg_reg.red_in_low_byte <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(cfg_reg.screen_height);
            REG_LINE_STRIDE:   prdata = APB_DATA_W'(cfg_reg.line_stride);
            REG_RED_LOW:       prdata = APB_DATA_W'(cfg_reg.red_in_low_byte);
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: hdl/rlebl_color.sv
// ---------------------------------------------------------------------------
// rlebl_color
// Widen an RGB565 colour to 8-bit channels and pack in the set order.
// ---------------------------------------------------------------------------
module rlebl_color (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [rlebl_pkg::COLOR_W-1:0] color,
    input  logic                           red_in_low_byte,
    output logic [rlebl_pkg::WORD_W-1:0]  word
);
    import rlebl_pkg::*;

    // floor(x/31) and floor(x/63) as multiply by 2^20 reciprocal, exact over range
    localparam int PROD_W  = 29;
    localparam int RECIP5  = 33826;
    localparam int RECIP6  = 16645;
    localparam int RSHIFT  = 20;

    logic [4:0]        r5, b5;
    logic [5:0]        g6;
    logic [12:0]       r_x, b_x;
    logic [13:0]       g_x;
    logic [PROD_W-1:0] r_prod, g_prod, b_prod;
    logic [7:0]        r8, g8, b8;
    logic [WORD_W-1:0] word_next;
    logic [WORD_W-1:0] word_reg;

    assign r5 = color[15:11];
    assign g6 = color[10:5];
    assign b5 = color[4:0];

    // c*255 as (c<<8) - c
    assign r_x = {r5, 8'd0} - 13'(r5);
    assign g_x = {g6, 8'd0} - 14'(g6);
    assign b_x = {b5, 8'd0} - 13'(b5);

    assign r_prod = PROD_W'(r_x) * PROD_W'(RECIP5);
    assign g_prod = PROD_W'(g_x) * PROD_W'(RECIP6);
    assign b_prod = PROD_W'(b_x) * PROD_W'(RECIP5);

    assign r8 = r_prod[RSHIFT+7:RSHIFT];
    assign g8 = g_prod[RSHIFT+7:RSHIFT];
    assign b8 = b_prod[RSHIFT+7:RSHIFT];

    assign word_next = red_in_low_byte ? {b8, g8, r8} : {r8, g8, b8};

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

FILE: hdl/rlebl_engine.sv
// ---------------------------------------------------------------------------
// rlebl_engine
// Run sequencer: sprite position, origin, row base and the pixel output stage.
// ---------------------------------------------------------------------------
`include "rle_rgb565_sprite_blitter_defines.svh"

module rlebl_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rlebl_pkg::cfg_t                 cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            start_image,
    input  logic [rlebl_pkg::LEN_W-1:0]    run_length,
    input  logic [rlebl_pkg::WORD_W-1:0]   run_word,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlebl_pkg::OFFSET_W-1:0] pixel_offset,
    output logic [rlebl_pkg::WORD_W-1:0]   pixel_word,
    output logic                            write_enable,
    output logic                            run_last
);
    import rlebl_pkg::*;

    eng_state_t state_reg, state_next;

    logic [LEN_W-1:0]    cnt_reg,  cnt_next;
    logic [COL_W-1:0]    col_reg,  col_next;
    logic [ROW_W-1:0]    row_reg,  row_next;
    logic [ORIGIN_W-1:0] ox_reg,   ox_next;
    logic [ORIGIN_W-1:0] oy_reg,   oy_next;
    logic [DIM_W-1:0]    sx_reg,   sx_next;
    logic [DIM_W-1:0]    sy_reg,   sy_next;
    logic [OFFSET_W-1:0] base_reg, base_next;

    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [WORD_W-1:0]   out_word_reg, out_word_next;
    logic                out_we_reg, out_we_next;
    logic                out_last_reg, out_last_next;

    logic                slot_free;
    logic                in_sprite;
    logic                on_screen;
    logic [DIM_W-1:0]    half_w, half_h;
    logic [LEN_W-1:0]    len_sat;

    assign slot_free = !out_valid_reg || m_tready;
    assign in_sprite = row_reg < ROW_W'(LOGO_HEIGHT);
    assign on_screen = in_sprite && (sx_reg < cfg.screen_width)
                       && (sy_reg < cfg.screen_height);
    assign half_w    = (cfg.screen_width  - DIM_W'(LOGO_WIDTH))  >> 1;
    assign half_h    = (cfg.screen_height - DIM_W'(LOGO_HEIGHT)) >> 1;
    assign len_sat   = (run_length > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : run_length;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        base_reg       <= base_next;
        out_offset_reg <= out_offset_next;
        out_word_reg   <= out_word_next;
        out_we_reg     <= out_we_next;
        out_last_reg   <= out_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        base_next       = base_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_offset_next = out_offset_reg;
        out_word_next   = out_word_reg;
        out_we_next     = out_we_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (start_image) begin
                        col_next = '0;
                        row_next = '0;
                    end
                    cnt_next   = len_sat;
                    state_next = (len_sat == '0) ? S_IDLE : S_ORIGIN;
                end
            end
            S_ORIGIN: begin
                // centre, lift the vertical origin, clamp both at zero
                ox_next = (cfg.screen_width > DIM_W'(LOGO_WIDTH))
                          ? half_w[ORIGIN_W-1:0] : '0;
                oy_next = ((cfg.screen_height > DIM_W'(LOGO_HEIGHT))
                           && (half_h > DIM_W'(ORIGIN_LIFT)))
                          ? ORIGIN_W'(half_h - DIM_W'(ORIGIN_LIFT)) : '0;
                state_next = S_POS;
            end
            S_POS: begin
                sx_next    = DIM_W'(ox_reg) + DIM_W'(col_reg);
                sy_next    = DIM_W'(oy_reg) + DIM_W'(row_reg);
                state_next = S_BASE;
            end
            S_BASE: begin
                base_next  = OFFSET_W'(sy_reg) * OFFSET_W'(cfg.line_stride);
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_we_next     = on_screen;
                    out_offset_next = on_screen ? (base_reg + OFFSET_W'(sx_reg)) : '0;
                    out_word_next   = on_screen ? run_word : '0;
                    out_last_next   = (cnt_reg == LEN_W'(1));
                    cnt_next        = cnt_reg - LEN_W'(1);
                    if (in_sprite) begin
                        if (col_reg == COL_W'(LOGO_WIDTH - 1)) begin
                            col_next  = '0;
                            row_next  = row_reg + ROW_W'(1);
                            sx_next   = DIM_W'(ox_reg);
                            sy_next   = sy_reg + DIM_W'(1);
                            base_next = base_reg + OFFSET_W'(cfg.line_stride);
                        end else begin
                            col_next = col_reg + COL_W'(1);
                            sx_next  = sx_reg + DIM_W'(1);
                        end
                    end
                    if (cnt_reg == LEN_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready     = (state_reg == S_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign pixel_offset = out_offset_reg;
    assign pixel_word   = out_word_reg;
    assign write_enable = out_we_reg;
    assign run_last     = out_last_reg;

    `RLEBL_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= LEN_W'(MAX_RUN))
    `RLEBL_ASSERT_NOW(a_emit_has_work, aclk, aresetn, state_reg == S_EMIT, cnt_reg != '0)
    `RLEBL_ASSERT_NOW(a_col_bound, aclk, aresetn, 1'b1, col_reg < COL_W'(LOGO_WIDTH))
    `RLEBL_ASSERT_NEXT(a_last_ends_run, aclk, aresetn, (state_reg == S_EMIT) && slot_free && (cnt_reg == LEN_W'(1)), (state_reg == S_IDLE) && out_valid_reg && out_last_reg)

endmodule

FILE: hdl/rle_rgb565_sprite_blitter.sv
// ---------------------------------------------------------------------------
// rle_rgb565_sprite_blitter
// Expands run-length RGB565 sprite runs into one framebuffer write per pixel.
// ---------------------------------------------------------------------------
//
//   port group   direction  handshake                   carries
//   s_*          in         s_tvalid / s_tready         one run request
//   m_*          out        m_tvalid / m_tready         one pixel write request
//   APB          in/out     psel, penable (pready = 1)  geometry and channel order
//
// A run of N pixels is accepted while s_tready is high, then s_tready is held low
// through three setup steps for origin, start position and row base (through the
// single stride multiplier) and the N pixel outputs, one pixel per cycle while
// m_tready does not stall the output stage.
// A run of length zero only applies its start flag and leaves the sequencer idle.
// Reset (aresetn low, synchronous) clears the position, the sequencer and the
// output stage, and loads the register defaults.
// A stalled m_tready holds the pixel stage; the sequencer waits with it.
// ---------------------------------------------------------------------------
module rle_rgb565_sprite_blitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlebl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rlebl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rlebl_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    // run requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [6:0] run_length, [22:7] run_color, [23] zero
    input  logic [rlebl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] start_image
    input  logic                              s_tuser,
    // pixel write requests
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [25:0] pixel_offset, [49:26] pixel_word, [55:50] zero
    output logic [rlebl_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] write_enable
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import rlebl_pkg::*;

    localparam int PAD_W = M_TDATA_W - OFFSET_W - WORD_W;

    cfg_t                cfg;
    logic [WORD_W-1:0]   run_word;
    logic [OFFSET_W-1:0] pixel_offset;
    logic [WORD_W-1:0]   pixel_word;
    logic                run_accept;

    assign run_accept = s_tvalid && s_tready;

    // register file
    rlebl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // widen and pack the colour once per run, at accept
    rlebl_color u_color (
        .aclk            (aclk),
        .load            (run_accept),
        .color           (s_tdata[LEN_W +: COLOR_W]),
        .red_in_low_byte (cfg.red_in_low_byte),
        .word            (run_word)
    );

    // sequencer and output stage
    rlebl_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .start_image  (s_tuser),
        .run_length   (s_tdata[LEN_W-1:0]),
        .run_word     (run_word),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .pixel_offset (pixel_offset),
        .pixel_word   (pixel_word),
        .write_enable (m_tuser),
        .run_last     (m_tlast)
    );

    // pack the pixel request, offset in the low bits
    assign m_tdata = {{PAD_W{1'b0}}, pixel_word, pixel_offset};

endmodule
